// ----- design/assert_macros.svh -----
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property.
`define CHK_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/a2m_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2m_pkg
// Types, codes and the operand schedule of the 2D affine matrix unit.
// ----------------------------------------------------------------------------
package a2m_pkg;

	localparam int W     = 32;
	localparam int ACC_W = 66;
	localparam int NCOEF = 6;

	typedef logic [2:0] opcode_t;
	localparam opcode_t OP_LOAD    = 3'd0;
	localparam opcode_t OP_IDENT   = 3'd1;
	localparam opcode_t OP_INVERT  = 3'd2;
	localparam opcode_t OP_PREPEND = 3'd3;
	localparam opcode_t OP_CONCAT  = 3'd4;

	// coefficient slots: a, b, c, d, tx, ty
	localparam logic [2:0] IX_TY = 3'd5;

	localparam logic signed [W-1:0] Q_ONE = 32'sh0001_0000;

	// multiplier operand sources: current matrix, operand item, constants
	typedef enum logic [3:0] {
		S_A, S_B, S_C, S_D, S_X, S_Y,
		S_IA, S_IB, S_IC, S_ID, S_ITX, S_ITY,
		S_ZERO, S_ONE
	} src_t;

	typedef struct packed {
		src_t x1;
		src_t y1;
		src_t x2;
		src_t y2;
		src_t base;
		logic sub;
	} term_t;

	typedef enum logic [1:0] {CM_KEEP, CM_NEW, CM_LOAD, CM_IDENT} commit_t;

	typedef struct packed {
		logic    latch;
		src_t    mul_x;
		src_t    mul_y;
		src_t    base;
		logic    acc_init;
		logic    acc_step;
		logic    acc_sub;
		logic    det_latch;
		logic    div_init;
		logic    div_k16;
		logic    div_step;
		logic    wr_en;
		logic    wr_div;
		logic [2:0] wr_idx;
		logic    commit;
		commit_t cmode;
		logic    sing;
	} cmd_t;

	typedef struct packed {
		logic acc_zero;
	} status_t;

	function automatic term_t mk(src_t x1, src_t y1, src_t x2, src_t y2, src_t base,
			logic sub);
		term_t t;
		t = '{x1, y1, x2, y2, base, sub};
		return t;
	endfunction

	// result = base + x1*y1 (+/-) x2*y2; for invert slot 0 is the determinant
	function automatic term_t term_of(opcode_t op, logic [2:0] idx);
		term_t t;
		t = mk(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
		if (op == OP_INVERT) begin
			case (idx)
				3'd0: t = mk(S_A, S_D, S_B, S_C, S_ZERO, 1'b1);
				3'd1: t = mk(S_D, S_ONE, S_ZERO, S_ZERO, S_ZERO, 1'b0);
				3'd2: t = mk(S_ZERO, S_ZERO, S_B, S_ONE, S_ZERO, 1'b1);
				3'd3: t = mk(S_ZERO, S_ZERO, S_C, S_ONE, S_ZERO, 1'b1);
				3'd4: t = mk(S_A, S_ONE, S_ZERO, S_ZERO, S_ZERO, 1'b0);
				3'd5: t = mk(S_C, S_Y, S_D, S_X, S_ZERO, 1'b1);
				3'd6: t = mk(S_X, S_B, S_Y, S_A, S_ZERO, 1'b1);
				default: t = mk(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
			endcase
		end else if (op == OP_PREPEND) begin
			case (idx)
				3'd0: t = mk(S_A, S_IA, S_C, S_IB, S_ZERO, 1'b0);
				3'd1: t = mk(S_B, S_IA, S_D, S_IB, S_ZERO, 1'b0);
				3'd2: t = mk(S_A, S_IC, S_C, S_ID, S_ZERO, 1'b0);
				3'd3: t = mk(S_B, S_IC, S_D, S_ID, S_ZERO, 1'b0);
				3'd4: t = mk(S_A, S_ITX, S_C, S_ITY, S_X, 1'b0);
				3'd5: t = mk(S_B, S_ITX, S_D, S_ITY, S_Y, 1'b0);
				default: t = mk(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
			endcase
		end else if (op == OP_CONCAT) begin
			case (idx)
				3'd0: t = mk(S_IA, S_A, S_IC, S_B, S_ZERO, 1'b0);
				3'd1: t = mk(S_IB, S_A, S_ID, S_B, S_ZERO, 1'b0);
				3'd2: t = mk(S_IA, S_C, S_IC, S_D, S_ZERO, 1'b0);
				3'd3: t = mk(S_IB, S_C, S_ID, S_D, S_ZERO, 1'b0);
				3'd4: t = mk(S_IA, S_X, S_IC, S_Y, S_ITX, 1'b0);
				3'd5: t = mk(S_IB, S_X, S_ID, S_Y, S_ITY, 1'b0);
				default: t = mk(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
			endcase
		end
		return t;
	endfunction

endpackage

// ----- design/a2m_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2m_req_if / a2m_rsp_if
// Valid/ready channels carrying one command item and one matrix item.
// ----------------------------------------------------------------------------
interface a2m_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [31:0] in_a;
	logic signed [31:0] in_b;
	logic signed [31:0] in_c;
	logic signed [31:0] in_d;
	logic signed [31:0] in_tx;
	logic signed [31:0] in_ty;
	modport source (output valid, opcode, in_a, in_b, in_c, in_d, in_tx, in_ty,
		input ready);
	modport sink (input valid, opcode, in_a, in_b, in_c, in_d, in_tx, in_ty,
		output ready);
endinterface

interface a2m_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_a;
	logic signed [31:0] out_b;
	logic signed [31:0] out_c;
	logic signed [31:0] out_d;
	logic signed [31:0] out_tx;
	logic signed [31:0] out_ty;
	logic               singular;
	modport source (output valid, out_a, out_b, out_c, out_d, out_tx, out_ty, singular,
		input ready);
	modport sink (input valid, out_a, out_b, out_c, out_d, out_tx, out_ty, singular,
		output ready);
endinterface

// ----- design/a2m_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2m_dp
// Matrix registers, shared 32x32 multiplier, accumulator and restoring divider.
// ----------------------------------------------------------------------------
module a2m_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  a2m_pkg::cmd_t                      cmd,
	output a2m_pkg::status_t                   stat,
	input  logic signed [a2m_pkg::W-1:0]       opnd [a2m_pkg::NCOEF],
	output logic signed [a2m_pkg::W-1:0]       coef [a2m_pkg::NCOEF],
	output logic                               singular
);

	localparam int AW = a2m_pkg::ACC_W;
	localparam int W  = a2m_pkg::W;

	logic signed [W-1:0]    cur_q [a2m_pkg::NCOEF];
	logic signed [W-1:0]    nxt_q [a2m_pkg::NCOEF];
	logic signed [W-1:0]    in_q  [a2m_pkg::NCOEF];
	logic                   sing_q;
	logic signed [2*W-1:0]  p_s1;
	logic signed [AW-1:0]   acc_q;
	logic [2*W-1:0]         den_q;
	logic                   det_neg_q;
	logic [2*W-1:0]         rem_q;
	logic [W-1:0]           low_q;
	logic [W-1:0]           quo_q;
	logic                   ovf_q;
	logic                   neg_q;

	logic signed [W-1:0]    mx, my, mbase;
	logic signed [2*W-1:0]  prod;
	logic signed [AW-1:0]   acc_neg;
	logic [2*W-1:0]         mag;
	logic [2*W-1:0]         hi;
	logic [W-1:0]           lo;
	logic [2*W:0]           trial;
	logic signed [AW-1:0]   tq;
	logic signed [W-1:0]    mac_res;
	logic signed [W-1:0]    div_res;

	localparam logic signed [AW-1:0] SAT_HI = AW'($signed(32'h7fff_ffff));
	localparam logic signed [AW-1:0] SAT_LO = AW'($signed(32'h8000_0000));

	function automatic logic signed [W-1:0] pick(a2m_pkg::src_t s,
			logic signed [W-1:0] c [a2m_pkg::NCOEF], logic signed [W-1:0] o [a2m_pkg::NCOEF]);
		logic signed [W-1:0] v;
		case (s)
			a2m_pkg::S_A:   v = c[0];
			a2m_pkg::S_B:   v = c[1];
			a2m_pkg::S_C:   v = c[2];
			a2m_pkg::S_D:   v = c[3];
			a2m_pkg::S_X:   v = c[4];
			a2m_pkg::S_Y:   v = c[5];
			a2m_pkg::S_IA:  v = o[0];
			a2m_pkg::S_IB:  v = o[1];
			a2m_pkg::S_IC:  v = o[2];
			a2m_pkg::S_ID:  v = o[3];
			a2m_pkg::S_ITX: v = o[4];
			a2m_pkg::S_ITY: v = o[5];
			a2m_pkg::S_ONE: v = 32'sd1;
			default:        v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mx    = pick(cmd.mul_x, cur_q, in_q);
		my    = pick(cmd.mul_y, cur_q, in_q);
		mbase = pick(cmd.base, cur_q, in_q);
		prod  = mx * my;
		acc_neg = -acc_q;
		mag   = acc_q[AW-1] ? acc_neg[2*W-1:0] : acc_q[2*W-1:0];
		// numerator scaled by 2^32 or 2^16; hi is the part above the quotient bits
		if (cmd.div_k16) begin
			hi = {16'b0, mag[2*W-1:16]};
			lo = {mag[15:0], 16'b0};
		end else begin
			hi = mag;
			lo = '0;
		end
		trial = {rem_q, low_q[W-1]};
		// Q32.32 -> Q16.16, toward zero
		tq = acc_q >>> 16;
		if (acc_q[AW-1] && (acc_q[15:0] != '0)) begin
			tq = tq + AW'(1);
		end
		if (tq > SAT_HI) begin
			mac_res = 32'sh7fff_ffff;
		end else if (tq < SAT_LO) begin
			mac_res = 32'sh8000_0000;
		end else begin
			mac_res = tq[W-1:0];
		end
		if (ovf_q) begin
			div_res = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (neg_q) begin
			div_res = quo_q[W-1] ? 32'sh8000_0000 : -$signed(quo_q);
		end else begin
			div_res = quo_q[W-1] ? 32'sh7fff_ffff : $signed(quo_q);
		end
		stat.acc_zero = (acc_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q[0] <= a2m_pkg::Q_ONE;
			cur_q[1] <= '0;
			cur_q[2] <= '0;
			cur_q[3] <= a2m_pkg::Q_ONE;
			cur_q[4] <= '0;
			cur_q[5] <= '0;
			sing_q   <= 1'b0;
		end else if (cmd.commit) begin
			sing_q <= cmd.sing;
			unique case (cmd.cmode)
				a2m_pkg::CM_KEEP: ;
				a2m_pkg::CM_NEW:  cur_q <= nxt_q;
				a2m_pkg::CM_LOAD: cur_q <= in_q;
				a2m_pkg::CM_IDENT: begin
					cur_q[0] <= a2m_pkg::Q_ONE;
					cur_q[1] <= '0;
					cur_q[2] <= '0;
					cur_q[3] <= a2m_pkg::Q_ONE;
					cur_q[4] <= '0;
					cur_q[5] <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			in_q <= opnd;
		end
		p_s1 <= prod;
		if (cmd.acc_init) begin
			acc_q <= (AW'(mbase) <<< 16) + AW'(p_s1);
		end else if (cmd.acc_step) begin
			acc_q <= cmd.acc_sub ? acc_q - AW'(p_s1) : acc_q + AW'(p_s1);
		end
		if (cmd.det_latch) begin
			den_q     <= mag;
			det_neg_q <= acc_q[AW-1];
		end
		if (cmd.div_init) begin
			ovf_q <= (hi >= den_q);
			rem_q <= hi;
			low_q <= lo;
			quo_q <= '0;
			neg_q <= acc_q[AW-1] ^ det_neg_q;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 64'(trial - {1'b0, den_q});
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[2*W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
			low_q <= {low_q[W-2:0], 1'b0};
		end
		if (cmd.wr_en) begin
			nxt_q[cmd.wr_idx] <= cmd.wr_div ? div_res : mac_res;
		end
	end

	assign coef     = cur_q;
	assign singular = sing_q;

endmodule

// ----- design/a2m_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2m_ctrl
// Sequencer: walks the product terms and divide steps of one item.
// ----------------------------------------------------------------------------
module a2m_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	output logic                out_valid,
	input  logic                out_ready,
	output a2m_pkg::cmd_t       cmd,
	input  a2m_pkg::status_t    stat
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_ACCUM, ST_CHECK,
		ST_DIVINIT, ST_DIV, ST_WRITE, ST_COMMIT, ST_DONE
	} state_t;

	state_t                 state_q;
	a2m_pkg::opcode_t       op_q;
	logic [2:0]             idx_q;
	logic [4:0]             cnt_q;
	logic                   sing_q;
	a2m_pkg::term_t         term;
	logic                   is_inv;
	logic [2:0]             slot;

	always_comb begin
		term   = a2m_pkg::term_of(op_q, idx_q);
		is_inv = (op_q == a2m_pkg::OP_INVERT);
		slot   = is_inv ? idx_q - 3'd1 : idx_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		cmd        = '0;
		cmd.wr_idx = slot;
		cmd.wr_div = is_inv;
		cmd.sing   = sing_q;
		cmd.div_k16 = (idx_q >= 3'd5);
		unique case (state_q)
			ST_IDLE:    cmd.latch = in_valid;
			ST_MUL1: begin
				cmd.mul_x = term.x1;
				cmd.mul_y = term.y1;
			end
			ST_MUL2: begin
				cmd.mul_x    = term.x2;
				cmd.mul_y    = term.y2;
				cmd.base     = term.base;
				cmd.acc_init = 1'b1;
			end
			ST_ACCUM: begin
				cmd.acc_step = 1'b1;
				cmd.acc_sub  = term.sub;
			end
			ST_CHECK:   cmd.det_latch = 1'b1;
			ST_DIVINIT: cmd.div_init = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_WRITE:   cmd.wr_en = 1'b1;
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				priority if (op_q == a2m_pkg::OP_LOAD)  cmd.cmode = a2m_pkg::CM_LOAD;
				else if (op_q == a2m_pkg::OP_IDENT)     cmd.cmode = a2m_pkg::CM_IDENT;
				else if (is_inv)  cmd.cmode = sing_q ? a2m_pkg::CM_KEEP : a2m_pkg::CM_NEW;
				else if (op_q == a2m_pkg::OP_PREPEND || op_q == a2m_pkg::OP_CONCAT)
					cmd.cmode = a2m_pkg::CM_NEW;
				else cmd.cmode = a2m_pkg::CM_KEEP;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= a2m_pkg::OP_LOAD;
			idx_q   <= '0;
			cnt_q   <= '0;
			sing_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						idx_q  <= '0;
						sing_q <= 1'b0;
						if (opcode == a2m_pkg::OP_INVERT || opcode == a2m_pkg::OP_PREPEND ||
								opcode == a2m_pkg::OP_CONCAT) begin
							state_q <= ST_MUL1;
						end else begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_ACCUM;
				ST_ACCUM: begin
					priority if (is_inv && idx_q == 3'd0) state_q <= ST_CHECK;
					else if (is_inv) state_q <= ST_DIVINIT;
					else state_q <= ST_WRITE;
				end
				ST_CHECK: begin
					// zero determinant: keep the matrix, flag it
					if (stat.acc_zero) begin
						sing_q  <= 1'b1;
						state_q <= ST_COMMIT;
					end else begin
						idx_q   <= 3'd1;
						state_q <= ST_MUL1;
					end
				end
				ST_DIVINIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (slot == a2m_pkg::IX_TY) begin
						state_q <= ST_COMMIT;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= ST_MUL1;
					end
				end
				ST_COMMIT: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/affine_2d_matrix_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_2d_matrix_unit
// Holds a 2x3 Q16.16 affine matrix and updates it by one opcode per item.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   opcode, in_a..in_ty
//  rsp      out  out_a..out_ty, singular
//
// One item at a time. Load, identity, unused: accept, then COMMIT, then the result in DONE.
// Prepend/concat: MUL1, MUL2, ACCUM, WRITE for each of 6 coefficients on the one multiplier.
// Invert: determinant, then per coefficient MUL1, MUL2, ACCUM, DIVINIT, a 32-step divider, WRITE.
// req.ready is high only when idle; a stalled result holds until taken.
// Reset leaves the identity matrix.
module affine_2d_matrix_unit (
	input  logic          clk,
	input  logic          arst_n,
	a2m_req_if.sink       req,
	a2m_rsp_if.source     rsp
);

	a2m_pkg::cmd_t        cmd;
	a2m_pkg::status_t     stat;
	logic signed [a2m_pkg::W-1:0] opnd [a2m_pkg::NCOEF];
	logic signed [a2m_pkg::W-1:0] coef [a2m_pkg::NCOEF];

	assign opnd[0] = req.in_a;
	assign opnd[1] = req.in_b;
	assign opnd[2] = req.in_c;
	assign opnd[3] = req.in_d;
	assign opnd[4] = req.in_tx;
	assign opnd[5] = req.in_ty;

	a2m_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.opcode    (req.opcode),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	a2m_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.opnd     (opnd),
		.coef     (coef),
		.singular (rsp.singular)
	);

	assign rsp.out_a  = coef[0];
	assign rsp.out_b  = coef[1];
	assign rsp.out_c  = coef[2];
	assign rsp.out_d  = coef[3];
	assign rsp.out_tx = coef[4];
	assign rsp.out_ty = coef[5];

endmodule

// ----- design/a2m_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2m_checker
// Port-level checks on the matrix unit's item flow.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2m_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready
);

	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`CHK_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item taken while busy")
	`CHK_NOW(a_no_overlap, !(rsp_valid && req_ready), "input open while result pending")
	`CHK_NEXT(a_no_dup, rsp_valid && rsp_ready, !rsp_valid, "result item repeated")

endmodule

bind affine_2d_matrix_unit a2m_checker u_a2m_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

// ----- tb/sv/affine_2d_matrix_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_2d_matrix_unit_tb
// Self-checking bench for the 2D affine matrix unit. A directed prelude
// covers each opcode, extreme coefficients, saturation, singular inversion
// and unused opcodes. Random command items follow, with random valid/ready
// gaps, one long result stall and one full drain. Every result matrix is
// checked against an in-bench model of the Q16.16 arithmetic.
// ----------------------------------------------------------------------------
module affine_2d_matrix_unit_tb;

	localparam int N_RANDOM   = 1925;
	localparam int CALM_TAIL  = 150;
	localparam int HOLD_LEN   = 300;
	localparam int MAX_CYCLES = 3000000;

	typedef struct {
		a2m_pkg::opcode_t op;
		int      v[6];
		bit      drain_first;
	} cmd_item_t;

	typedef struct {
		int v[6];
		bit singular;
	} matrix_out_t;

	logic clk;
	logic arst_n;
	a2m_req_if req_ch();
	a2m_rsp_if rsp_ch();

	affine_2d_matrix_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	cmd_item_t   pending_cmds[$];
	matrix_out_t expected_mats[$];
	int          model_mat[6];
	int          total_cmds;
	int          sent_cmds;
	int          checked_mats;
	int          errors;
	int          cycles;
	int          op_hits[8];
	int          singular_hits;
	bit          req_taken;
	int          send_gap;
	int          recv_gap;
	int          hold_cnt;
	bit          hold_done;
	string       field_names[7] = '{"a", "b", "c", "d", "tx", "ty", "singular"};

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------- Q16.16 model ----------------
	function automatic int sat32(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -128'sd2147483648)
			return 32'h8000_0000;
		return int'(v);
	endfunction

	// (base*2^16 + x1*y1 + x2*y2) / 2^16, toward zero
	function automatic int mac_q16(int base, int x1, int y1, int x2, int y2);
		logic signed [127:0] s;
		logic signed [127:0] b, p, q, r, t;
		b = base; p = x1; q = y1; r = x2; t = y2;
		s = b * 65536 + p * q + r * t;
		return sat32(s / 65536);
	endfunction

	// n * 2^k / det, toward zero, saturated
	function automatic int div_scaled(logic signed [127:0] n, int k,
			logic signed [127:0] det);
		logic [127:0] mn, md, quo;
		bit neg;
		mn = n < 0 ? -n : n;
		md = det < 0 ? -det : det;
		neg = (n < 0) != (det < 0);
		quo = (mn << k) / md;
		if (neg)
			return quo >= 128'd2147483648 ? 32'h8000_0000 : -int'(quo);
		return quo > 128'd2147483647 ? 32'h7fff_ffff : int'(quo);
	endfunction

	function automatic matrix_out_t apply_cmd(cmd_item_t it);
		matrix_out_t res;
		int A, B, C, D, X, Y;
		int o[6];
		logic signed [127:0] det, numx, numy, sa, sb, sc, sd, sx, sy;
		A = model_mat[0]; B = model_mat[1]; C = model_mat[2];
		D = model_mat[3]; X = model_mat[4]; Y = model_mat[5];
		o = model_mat;
		res.singular = 1'b0;
		case (it.op)
			a2m_pkg::OP_LOAD: o = it.v;
			a2m_pkg::OP_IDENT: o = '{a2m_pkg::Q_ONE, 0, 0, a2m_pkg::Q_ONE, 0, 0};
			a2m_pkg::OP_INVERT: begin
				sa = A; sb = B; sc = C; sd = D; sx = X; sy = Y;
				det = sa * sd - sb * sc;
				if (det == 0) begin
					res.singular = 1'b1;
				end else begin
					numx = sc * sy - sd * sx;
					numy = sx * sb - sy * sa;
					o[0] = div_scaled(sd, 32, det);
					o[1] = div_scaled(-sb, 32, det);
					o[2] = div_scaled(-sc, 32, det);
					o[3] = div_scaled(sa, 32, det);
					o[4] = div_scaled(numx, 16, det);
					o[5] = div_scaled(numy, 16, det);
				end
			end
			a2m_pkg::OP_PREPEND: begin
				o[0] = mac_q16(0, A, it.v[0], C, it.v[1]);
				o[1] = mac_q16(0, B, it.v[0], D, it.v[1]);
				o[2] = mac_q16(0, A, it.v[2], C, it.v[3]);
				o[3] = mac_q16(0, B, it.v[2], D, it.v[3]);
				o[4] = mac_q16(X, A, it.v[4], C, it.v[5]);
				o[5] = mac_q16(Y, B, it.v[4], D, it.v[5]);
			end
			a2m_pkg::OP_CONCAT: begin
				o[0] = mac_q16(0, it.v[0], A, it.v[2], B);
				o[1] = mac_q16(0, it.v[1], A, it.v[3], B);
				o[2] = mac_q16(0, it.v[0], C, it.v[2], D);
				o[3] = mac_q16(0, it.v[1], C, it.v[3], D);
				o[4] = mac_q16(it.v[4], it.v[0], X, it.v[2], Y);
				o[5] = mac_q16(it.v[5], it.v[1], X, it.v[3], Y);
			end
			default: ;
		endcase
		model_mat = o;
		res.v = o;
		return res;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic int rand_coef();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			2: return 0;
			3: return $urandom_range(0, 1) ? a2m_pkg::Q_ONE : -a2m_pkg::Q_ONE;
			4, 5: return int'($urandom_range(0, 32'h0007_ffff)) - 32'h0004_0000;
			default: return int'($urandom_range(0, 32'h0001_ffff)) - 32'h0001_0000;
		endcase
	endfunction

	task automatic add_cmd(a2m_pkg::opcode_t op, int a, int b, int c, int d, int x, int y,
			bit drain = 1'b0);
		cmd_item_t it;
		it.op = op;
		it.v = '{a, b, c, d, x, y};
		it.drain_first = drain;
		pending_cmds.push_back(it);
	endtask

	task automatic add_random_cmd(bit drain);
		int a, b, c, d, k;
		k = $urandom_range(0, 99);
		a = rand_coef(); b = rand_coef(); c = rand_coef(); d = rand_coef();
		if (k < 15) begin
			add_cmd(a2m_pkg::OP_LOAD, a, b, c, d, rand_coef(), rand_coef(), drain);
		end else if (k < 20) begin
			// columns equal: zero determinant
			add_cmd(a2m_pkg::OP_LOAD, a, b, a, b, rand_coef(), rand_coef(), drain);
		end else if (k < 25) begin
			add_cmd(a2m_pkg::OP_IDENT, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), drain);
		end else if (k < 42) begin
			add_cmd(a2m_pkg::OP_INVERT, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), drain);
		end else if (k < 68) begin
			add_cmd(a2m_pkg::OP_PREPEND, a, b, c, d, rand_coef(), rand_coef(), drain);
		end else if (k < 94) begin
			add_cmd(a2m_pkg::OP_CONCAT, a, b, c, d, rand_coef(), rand_coef(), drain);
		end else begin
			add_cmd(a2m_pkg::opcode_t'($urandom_range(5, 7)), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), drain);
		end
	endtask

	// ---------------- driver ----------------
	always @(negedge clk) begin
		cmd_item_t it;
		bit calm;
		calm = sent_cmds >= total_cmds - CALM_TAIL;
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (pending_cmds[0].drain_first && expected_mats.size() != 0) begin
				req_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 3);
				req_ch.valid <= 1'b0;
			end else begin
				it = pending_cmds.pop_front();
				req_ch.valid  <= 1'b1;
				req_ch.opcode <= it.op;
				req_ch.in_a   <= it.v[0];
				req_ch.in_b   <= it.v[1];
				req_ch.in_c   <= it.v[2];
				req_ch.in_d   <= it.v[3];
				req_ch.in_tx  <= it.v[4];
				req_ch.in_ty  <= it.v[5];
			end
		end
	end

	// ---------------- result side back-pressure ----------------
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && sent_cmds >= 600) begin
			rsp_ch.ready <= 1'b0;
			if (hold_cnt == HOLD_LEN)
				hold_done <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else if (sent_cmds >= total_cmds - CALM_TAIL) begin
			rsp_ch.ready <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 3);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// ---------------- monitor / checker ----------------
	always @(posedge clk) begin
		cmd_item_t it;
		matrix_out_t exp_m, got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.v = '{rsp_ch.out_a, rsp_ch.out_b, rsp_ch.out_c, rsp_ch.out_d,
				rsp_ch.out_tx, rsp_ch.out_ty};
			got.singular = rsp_ch.singular;
			if (expected_mats.size() == 0) begin
				$display("%0t: unexpected result item, a=%h singular=%b", $time,
					got.v[0], got.singular);
				errors++;
			end else begin
				exp_m = expected_mats.pop_front();
				checked_mats++;
				for (int i = 0; i < 6; i++)
					if (got.v[i] !== exp_m.v[i]) begin
						$display("%0t: item %0d field %s expected %h actual %h", $time,
							checked_mats, field_names[i], exp_m.v[i], got.v[i]);
						errors++;
					end
				if (got.singular !== exp_m.singular) begin
					$display("%0t: item %0d field %s expected %b actual %b", $time,
						checked_mats, field_names[6], exp_m.singular, got.singular);
					errors++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			it.op = req_ch.opcode;
			it.v = '{req_ch.in_a, req_ch.in_b, req_ch.in_c, req_ch.in_d,
				req_ch.in_tx, req_ch.in_ty};
			exp_m = apply_cmd(it);
			expected_mats.push_back(exp_m);
			op_hits[it.op]++;
			singular_hits += exp_m.singular;
			sent_cmds++;
			req_taken <= 1'b1;
		end else begin
			req_taken <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d items pending", cycles,
				expected_mats.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int last_hit;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = a2m_pkg::OP_LOAD;
		req_ch.in_a = 0; req_ch.in_b = 0; req_ch.in_c = 0;
		req_ch.in_d = 0; req_ch.in_tx = 0; req_ch.in_ty = 0;
		rsp_ch.ready = 1'b0;
		model_mat = '{a2m_pkg::Q_ONE, 0, 0, a2m_pkg::Q_ONE, 0, 0};
		req_taken = 0; send_gap = 0; recv_gap = 0; hold_cnt = 0; hold_done = 0;
		sent_cmds = 0; checked_mats = 0; errors = 0; cycles = 0; singular_hits = 0;
		foreach (op_hits[i])
			op_hits[i] = 0;

		// directed prelude
		add_cmd(a2m_pkg::opcode_t'(7), 0, 0, 0, 0, 0, 0);   // shows reset identity
		add_cmd(a2m_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0);      // inverse of identity
		add_cmd(a2m_pkg::OP_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		add_cmd(a2m_pkg::OP_PREPEND, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000); // saturates
		add_cmd(a2m_pkg::OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_cmd(a2m_pkg::OP_CONCAT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		add_cmd(a2m_pkg::OP_IDENT, -1, -1, -1, -1, -1, -1);
		add_cmd(a2m_pkg::OP_LOAD, 0, 0, 0, 0, 32'h0003_0000, -32'h0002_0000);
		add_cmd(a2m_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0);      // zero determinant
		add_cmd(a2m_pkg::OP_LOAD, 1, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000);
		add_cmd(a2m_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0);      // tiny det, huge result
		add_cmd(a2m_pkg::OP_LOAD, 32'h0002_0000, 32'h0000_8000, -32'h0001_0000,
			32'h0003_0000, 32'h0010_0000, -32'h0000_0001);
		add_cmd(a2m_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0);
		add_cmd(a2m_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0);
		add_cmd(a2m_pkg::OP_PREPEND, -3, 5, -7, 11, -13, 17); // rounding toward zero
		add_cmd(a2m_pkg::OP_CONCAT, 3, -5, 7, -11, 13, -17);
		add_cmd(a2m_pkg::opcode_t'(5), 32'h7fff_ffff, 0, 0, 0, 0, 0);
		add_cmd(a2m_pkg::opcode_t'(6), 0, 0, 0, 0, 0, 0);
		add_cmd(a2m_pkg::OP_LOAD, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
		add_cmd(a2m_pkg::OP_LOAD, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
		add_cmd(a2m_pkg::OP_IDENT, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < N_RANDOM; i++)
			add_random_cmd(i == N_RANDOM / 2);
		total_cmds = pending_cmds.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (sent_cmds == total_cmds && pending_cmds.size() == 0);
		wait (expected_mats.size() == 0);
		last_hit = checked_mats;
		repeat (300) @(posedge clk);

		$display("%0d items checked: load %0d, identity %0d, invert %0d (%0d singular)",
			checked_mats, op_hits[a2m_pkg::OP_LOAD], op_hits[a2m_pkg::OP_IDENT],
			op_hits[a2m_pkg::OP_INVERT], singular_hits);
		$display("prepend %0d, concat %0d, unused opcodes %0d, %0d mismatches",
			op_hits[a2m_pkg::OP_PREPEND], op_hits[a2m_pkg::OP_CONCAT],
			op_hits[5] + op_hits[6] + op_hits[7], errors);
		if (errors == 0 && checked_mats == last_hit && expected_mats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
